>>> src/cfbf_pkg.sv
// Shared types for the complex block FIR filter: controller states, command and status groups.
package cfbf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_PUT,
    ST_FLUSH,
    ST_CLEAR
  } cfbf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic tap_wr;
    logic shift_in;
    logic shift_zero;
    logic hist_clr;
    logic mac_issue;
    logic mac_first;
    logic mac_last;
    logic out_load;
    logic out_last;
  } cfbf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic res_ready;
    logic out_free;
  } cfbf_status_t;

endpackage

>>> src/cfbf_ctrl.sv
// Controller for the complex block FIR filter: block counting, flush sequencing, MAC issue.
module cfbf_ctrl #(
  parameter int NUM_TAPS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_mode,
  input  logic                          in_eob,
  output cfbf_pkg::cfbf_cmd_t           cmd,
  output logic [$clog2(NUM_TAPS)-1:0]   mac_idx,
  input  cfbf_pkg::cfbf_status_t        status
);
  import cfbf_pkg::*;

  localparam int D  = (NUM_TAPS - 1) / 2;
  localparam int AW = $clog2(NUM_TAPS);
  localparam int KW = $clog2(D + 1);
  localparam logic [KW-1:0] D_K    = KW'(D);
  localparam logic [KW-1:0] D_LAST = KW'(D - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(NUM_TAPS - 1);

  cfbf_state_t     state_r, state_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            eob_r, eob_nxt;
  logic            flush_r, flush_nxt;
  logic            last_r, last_nxt;
  logic [KW:0]     fill_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      idx_r   <= '0;
      eob_r   <= 1'b0;
      flush_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
      eob_r   <= eob_nxt;
      flush_r <= flush_nxt;
      last_r  <= last_nxt;
    end
  end

  assign fill_sum = {1'b0, cnt_r} + {1'b0, k_r};
  assign mac_idx  = idx_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    eob_nxt   = eob_r;
    flush_nxt = flush_r;
    last_nxt  = last_r;
    in_tready = 1'b0;
    cmd       = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode) begin
            cmd.tap_wr = 1'b1;
          end else begin
            cmd.shift_in = 1'b1;
            eob_nxt   = in_eob;
            flush_nxt = 1'b0;
            k_nxt     = '0;
            if (cnt_r != D_K) cnt_nxt = cnt_r + KW'(1);
            if (cnt_r == D_K) begin
              idx_nxt   = '0;
              last_nxt  = 1'b0;
              state_nxt = ST_MAC;
            end else if (in_eob) begin
              flush_nxt = 1'b1;
              state_nxt = ST_FLUSH;
            end
          end
        end
      end

      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (idx_r == '0);
        cmd.mac_last  = (idx_r == IDX_LAST);
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_WAIT;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      ST_WAIT: begin
        if (status.res_ready) state_nxt = ST_PUT;
      end

      ST_PUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_r;
          if (flush_r) begin
            if (k_r == D_LAST) begin
              state_nxt = ST_CLEAR;
            end else begin
              k_nxt     = k_r + KW'(1);
              state_nxt = ST_FLUSH;
            end
          end else if (eob_r) begin
            flush_nxt = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        cmd.shift_zero = 1'b1;
        last_nxt = (k_r == D_LAST);
        if (fill_sum >= {1'b0, D_K}) begin
          idx_nxt   = '0;
          state_nxt = ST_MAC;
        end else if (k_r == D_LAST) begin
          state_nxt = ST_CLEAR;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      ST_CLEAR: begin
        cmd.hist_clr = 1'b1;
        cnt_nxt   = '0;
        flush_nxt = 1'b0;
        eob_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output loaded while the output word is still held");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= D_K)
    else $error("block counter beyond the group delay");

  a_clear_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |=> cnt_r == '0 && state_r == ST_IDLE)
    else $error("block counter not cleared after flush");

  a_mac_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_last |=> state_r == ST_WAIT)
    else $error("last MAC issue not followed by wait");

endmodule

>>> src/cfbf_datapath.sv
// Datapath for the complex block FIR filter: delay lines, tap memory, MAC pipeline, output word.
module cfbf_datapath #(
  parameter int NUM_TAPS    = 31,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfbf_pkg::cfbf_cmd_t                 cmd,
  input  logic [$clog2(NUM_TAPS)-1:0]         mac_idx,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_q,
  input  logic [4:0]                          tap_index,
  input  logic signed [COEF_BITS-1:0]         tap_value,
  output cfbf_pkg::cfbf_status_t              status,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [SAMPLE_BITS-1:0]       out_i,
  output logic signed [SAMPLE_BITS-1:0]       out_q,
  output logic                                out_clipped,
  output logic                                out_last
);
  import cfbf_pkg::*;

  localparam int AW    = $clog2(NUM_TAPS);
  localparam int FRAC  = COEF_BITS - 2;
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W = PW + $clog2(NUM_TAPS);
  localparam int HI_W  = ACC_W - (FRAC + SAMPLE_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] hist_i_r [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_q_r [NUM_TAPS];
  logic signed [COEF_BITS-1:0]   tap_mem  [NUM_TAPS];
  logic [NUM_TAPS-1:0]           tap_vld_r;

  logic signed [COEF_BITS-1:0]   tap_rd_r;
  logic                          tvld_rd_r;
  logic signed [SAMPLE_BITS-1:0] hi1_r, hq1_r;
  logic                          v1_r, f1_r, l1_r;
  logic signed [PW-1:0]          pi_r, pq_r;
  logic                          v2_r, f2_r, l2_r;
  logic signed [ACC_W-1:0]       acc_i_r, acc_q_r;
  logic                          l3_r;
  logic signed [ACC_W-1:0]       rnd_i_r, rnd_q_r;
  logic                          res_ready_r;
  logic signed [COEF_BITS-1:0]   coef;
  logic                          tap_ok;
  logic [AW-1:0]                 wr_addr;

  logic                          out_tvalid_r;
  logic signed [SAMPLE_BITS-1:0] out_i_r, out_q_r;
  logic                          out_clipped_r, out_last_r;

  logic [HI_W-1:0]               hi_i, hi_q;
  logic                          ovf_i, ovf_q;
  logic signed [SAMPLE_BITS-1:0] sat_i, sat_q;

  assign tap_ok  = (32'(tap_index) < 32'(NUM_TAPS));
  assign wr_addr = AW'(tap_index);

  // Delay lines: shift on a new sample or a flush zero, rotate during MAC so entry 0 walks the taps
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.hist_clr) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        hist_i_r[j] <= '0;
        hist_q_r[j] <= '0;
      end
    end else if (cmd.shift_in || cmd.shift_zero) begin
      for (int j = NUM_TAPS - 1; j > 0; j--) begin
        hist_i_r[j] <= hist_i_r[j-1];
        hist_q_r[j] <= hist_q_r[j-1];
      end
      hist_i_r[0] <= cmd.shift_in ? sample_i : '0;
      hist_q_r[0] <= cmd.shift_in ? sample_q : '0;
    end else if (cmd.mac_issue) begin
      for (int j = 0; j < NUM_TAPS - 1; j++) begin
        hist_i_r[j] <= hist_i_r[j+1];
        hist_q_r[j] <= hist_q_r[j+1];
      end
      hist_i_r[NUM_TAPS-1] <= hist_i_r[0];
      hist_q_r[NUM_TAPS-1] <= hist_q_r[0];
    end
  end

  // Tap memory; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.tap_wr && tap_ok) tap_mem[wr_addr] <= tap_value;
    if (cmd.mac_issue) tap_rd_r <= tap_mem[mac_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r <= '0;
      tvld_rd_r <= 1'b0;
    end else begin
      if (cmd.tap_wr && tap_ok) tap_vld_r[wr_addr] <= 1'b1;
      if (cmd.mac_issue) tvld_rd_r <= tap_vld_r[mac_idx];
    end
  end

  // MAC pipeline: fetch, multiply, accumulate, round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      l3_r        <= 1'b0;
      res_ready_r <= 1'b0;
      f1_r        <= 1'b0;
      l1_r        <= 1'b0;
      f2_r        <= 1'b0;
      l2_r        <= 1'b0;
    end else begin
      v1_r        <= cmd.mac_issue;
      f1_r        <= cmd.mac_first;
      l1_r        <= cmd.mac_last;
      v2_r        <= v1_r;
      f2_r        <= f1_r;
      l2_r        <= v1_r && l1_r;
      l3_r        <= v2_r && l2_r;
      res_ready_r <= l3_r;
    end
  end

  assign coef = tvld_rd_r ? tap_rd_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      hi1_r <= hist_i_r[0];
      hq1_r <= hist_q_r[0];
    end
    if (v1_r) begin
      pi_r <= coef * hi1_r;
      pq_r <= coef * hq1_r;
    end
    if (v2_r) begin
      acc_i_r <= f2_r ? ACC_W'(pi_r) : acc_i_r + ACC_W'(pi_r);
      acc_q_r <= f2_r ? ACC_W'(pq_r) : acc_q_r + ACC_W'(pq_r);
    end
    if (l3_r) begin
      rnd_i_r <= acc_i_r + HALF;
      rnd_q_r <= acc_q_r + HALF;
    end
  end

  // Saturate the floor-shifted sum: all bits above the sample's sign bit must agree
  assign hi_i  = rnd_i_r[ACC_W-1 -: HI_W];
  assign hi_q  = rnd_q_r[ACC_W-1 -: HI_W];
  assign ovf_i = !((&hi_i) || !(|hi_i));
  assign ovf_q = !((&hi_q) || !(|hi_q));
  assign sat_i = ovf_i ? (rnd_i_r[ACC_W-1] ? SMIN : SMAX)
                       : rnd_i_r[FRAC +: SAMPLE_BITS];
  assign sat_q = ovf_q ? (rnd_q_r[ACC_W-1] ? SMIN : SMAX)
                       : rnd_q_r[FRAC +: SAMPLE_BITS];

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_i_r       <= sat_i;
      out_q_r       <= sat_q;
      out_clipped_r <= ovf_i || ovf_q;
      out_last_r    <= cmd.out_last;
    end
  end

  assign status.res_ready = res_ready_r;
  assign status.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid  = out_tvalid_r;
  assign out_i       = out_i_r;
  assign out_q       = out_q_r;
  assign out_clipped = out_clipped_r;
  assign out_last    = out_last_r;

endmodule

>>> src/complex_fir_block_filter.sv
// Complex block FIR filter top level: stream ports, field unpacking, controller and datapath.
//
// Odd-length FIR with real Q1.(COEF_BITS-2) taps on complex I/Q samples, one block at a
// time with the group delay D = (NUM_TAPS-1)/2 removed. in_tuser = 1 loads one tap;
// in_tuser = 0 filters a sample. For each output one shared multiply-accumulate per
// rail walks the taps one per cycle, then a three-stage multiply/accumulate/round
// pipeline drains before the word is registered. A sample with in_tlast set starts a
// flush of D zero steps (each step that outputs also runs the MAC) and a clear of the
// delay lines, so each block returns as many words as it took samples, the last one
// flagged on out_tlast. The output word is held in its own register, so a new sample
// is taken while an earlier result waits on out_tready.
module complex_fir_block_filter #(
  parameter int NUM_TAPS    = 31,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // sample_i, sample_q, tap_index, tap_value, zero pad
  input  logic [((2*SAMPLE_BITS + 5 + COEF_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // mode
  input  logic                                             in_tuser,
  input  logic                                             in_tlast,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // out_i, out_q
  output logic [((2*SAMPLE_BITS + 7) / 8) * 8 - 1:0]      out_tdata,
  // clipped
  output logic                                             out_tuser,
  output logic                                             out_tlast
);
  import cfbf_pkg::*;

  localparam int AW     = $clog2(NUM_TAPS);
  localparam int OUT_DW = ((2*SAMPLE_BITS + 7) / 8) * 8;
  localparam int TI_LSB = 2 * SAMPLE_BITS;
  localparam int TV_LSB = 2 * SAMPLE_BITS + 5;

  cfbf_cmd_t                     cmd;
  cfbf_status_t                  status;
  logic [AW-1:0]                 mac_idx;
  logic signed [SAMPLE_BITS-1:0] sample_i, sample_q;
  logic [4:0]                    tap_index;
  logic signed [COEF_BITS-1:0]   tap_value;
  logic signed [SAMPLE_BITS-1:0] res_i, res_q;

  assign sample_i  = in_tdata[0 +: SAMPLE_BITS];
  assign sample_q  = in_tdata[SAMPLE_BITS +: SAMPLE_BITS];
  assign tap_index = in_tdata[TI_LSB +: 5];
  assign tap_value = in_tdata[TV_LSB +: COEF_BITS];

  cfbf_ctrl #(
    .NUM_TAPS (NUM_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_eob    (in_tlast),
    .cmd       (cmd),
    .mac_idx   (mac_idx),
    .status    (status)
  );

  cfbf_datapath #(
    .NUM_TAPS    (NUM_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .mac_idx     (mac_idx),
    .sample_i    (sample_i),
    .sample_q    (sample_q),
    .tap_index   (tap_index),
    .tap_value   (tap_value),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_i       (res_i),
    .out_q       (res_q),
    .out_clipped (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = OUT_DW'({res_q, res_i});

endmodule

>>> test/complex_fir_block_filter_tb.sv
// Testbench for the complex block FIR filter: directed and random blocks checked word by word.
module complex_fir_block_filter_tb;

  localparam int TAPS = 31;
  localparam int HALF = (TAPS - 1) / 2;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef struct {
    logic signed [15:0] oi;
    logic signed [15:0] oq;
    logic               clip;
    logic               last;
  } fir_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // sample_i, sample_q, tap_index, tap_value, zero pad
  logic [55:0] in_tdata = '0;
  // mode
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_i, out_q
  logic [31:0] out_tdata;
  // clipped
  logic        out_tuser;
  logic        out_tlast;

  complex_fir_block_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // filter predictor state
  logic signed [15:0] hist_i [TAPS];
  logic signed [15:0] hist_q [TAPS];
  logic signed [17:0] coefs  [TAPS];
  int                 block_fill;
  fir_word_t          pending_words[$];

  int errors = 0;
  int n_samples = 0;
  int n_loads = 0;
  int n_blocks = 0;
  int n_words = 0;
  int n_clipped = 0;

  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  int rx_hold_len = 0;
  bit rx_hold_go = 1'b0;
  bit rx_hold_seen = 1'b0;
  int rx_hold_left = 0;
  int rx_gap_left = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [15:0] round_sat(input longint acc, inout logic clip);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (r > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (r < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic void shift_hist(input logic signed [15:0] si, input logic signed [15:0] sq);
    for (int j = TAPS - 1; j > 0; j--) begin
      hist_i[j] = hist_i[j - 1];
      hist_q[j] = hist_q[j - 1];
    end
    hist_i[0] = si;
    hist_q[0] = sq;
  endfunction

  function automatic void push_sum(input logic last);
    longint    acc_i;
    longint    acc_q;
    fir_word_t w;
    acc_i = 0;
    acc_q = 0;
    for (int j = 0; j < TAPS; j++) begin
      acc_i += longint'(coefs[j]) * longint'(hist_i[j]);
      acc_q += longint'(coefs[j]) * longint'(hist_q[j]);
    end
    w.clip = 1'b0;
    w.oi = round_sat(acc_i, w.clip);
    w.oq = round_sat(acc_q, w.clip);
    w.last = last;
    pending_words.push_back(w);
  endfunction

  function automatic void fir_predict(input logic mode, input logic signed [15:0] si,
                                      input logic signed [15:0] sq, input logic eob,
                                      input logic [4:0] idx, input logic signed [17:0] val);
    if (mode == MODE_LOAD) begin
      if (idx < TAPS) coefs[idx] = val;
      return;
    end
    shift_hist(si, sq);
    if (block_fill >= HALF) push_sum(1'b0);
    if (block_fill < HALF) block_fill++;
    if (eob) begin
      // flush with zeros so the block returns one word per sample
      for (int k = 0; k < HALF; k++) begin
        shift_hist(16'sd0, 16'sd0);
        if (block_fill + k >= HALF) push_sum(k == HALF - 1);
      end
      for (int j = 0; j < TAPS; j++) begin
        hist_i[j] = '0;
        hist_q[j] = '0;
      end
      block_fill = 0;
    end
  endfunction

  task automatic send_word(input logic mode, input logic signed [15:0] si,
                           input logic signed [15:0] sq, input logic eob,
                           input logic [4:0] idx, input logic signed [17:0] val);
    int gap;
    in_tdata  <= {1'b0, val, idx, sq, si};
    in_tuser  <= mode;
    in_tlast  <= eob;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    fir_predict(mode, si, sq, eob, idx, val);
    if (mode == MODE_LOAD) n_loads++;
    else begin
      n_samples++;
      if (eob) n_blocks++;
    end
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq,
                             input logic eob);
    send_word(MODE_FILTER, si, sq, eob, 5'($urandom), 18'($urandom));
  endtask

  task automatic send_tap(input logic [4:0] idx, input logic signed [17:0] val);
    send_word(MODE_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), idx, val);
  endtask

  // stop offering words until every predicted word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus an occasional long hold requested by a test
  always @(posedge clk) begin
    if (rx_hold_go != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_go;
      rx_hold_left <= rx_hold_len;
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left <= rx_gap_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
      rx_gap_left <= pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fir_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word i=%0d q=%0d clip=%0b last=%0b", $time,
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser, out_tlast);
      end else begin
        w = pending_words.pop_front();
        n_words++;
        if (w.clip) n_clipped++;
        if (out_tdata[15:0] !== w.oi || out_tdata[31:16] !== w.oq ||
            out_tuser !== w.clip || out_tlast !== w.last) begin
          errors++;
          $display("%0t: mismatch expected i=%0d q=%0d clip=%0b last=%0b got i=%0d q=%0d clip=%0b last=%0b",
                   $time, w.oi, w.oq, w.clip, w.last, $signed(out_tdata[15:0]),
                   $signed(out_tdata[31:16]), out_tuser, out_tlast);
        end
      end
    end
  end

  // extreme coefficients, an out-of-range index and a load with stray sample fields
  task automatic test_tap_extremes();
    send_word(MODE_LOAD, 16'sd0, 16'sd0, 1'b0, 5'd0, 18'sh1ffff);
    send_word(MODE_LOAD, 16'sd0, 16'sd0, 1'b0, 5'd1, 18'sh1ffff);
    send_word(MODE_LOAD, 16'sd0, 16'sd0, 1'b0, 5'd15, 18'sd65536);
    send_word(MODE_LOAD, 16'sd0, 16'sd0, 1'b0, 5'd30, 18'sh20000);
    send_word(MODE_LOAD, 16'sd0, 16'sd0, 1'b0, 5'd31, 18'sh15555);
    send_word(MODE_LOAD, 16'sh7fff, 16'sh8000, 1'b1, 5'd2, -18'sd3);
  endtask

  // one-sample block, then a full block driven into saturation both ways
  task automatic test_block_edges();
    send_sample(16'sh8000, 16'sh7fff, 1'b1);
    for (int n = 0; n < 16; n++) begin
      if (n < 8) send_sample(16'sh7fff, 16'sh8000, 1'b0);
      else if (n[0]) send_sample(16'sh8000, 16'sh7fff, n == 15);
      else send_sample(16'sh7fff, 16'sh8000, 1'b0);
    end
    drain();
  endtask

  task automatic test_random_blocks(input int n_items);
    int sent;
    int len;
    logic signed [17:0] val;
    sent = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          val = ($urandom_range(0, 2) == 0) ? 18'($urandom)
                                            : 18'($signed($urandom_range(0, 16383)) - 8192);
          send_tap(5'($urandom), val);
          sent++;
        end
        send_sample(16'($urandom), 16'($urandom), n == len - 1);
        sent++;
      end
      // a quiet stretch now and then
      if ($urandom_range(0, 5) == 0) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end else begin
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
      end
    end
    drain();
  endtask

  // receiver holds off long enough for the filter to back up onto its input
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    rx_hold_len = 400;
    rx_hold_go <= ~rx_hold_go;
    for (int n = 0; n < 24; n++)
      send_sample(16'($urandom), 16'($urandom), n == 23);
    drain();
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    for (int j = 0; j < TAPS; j++) begin
      hist_i[j] = '0;
      hist_q[j] = '0;
      coefs[j] = '0;
    end
    block_fill = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tap_extremes();
    test_block_edges();
    test_random_blocks(75);
    test_backpressure();

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d samples in %0d blocks and %0d tap loads", n_samples, n_blocks, n_loads);
    $display("checked %0d output words, %0d of them saturated", n_words, n_clipped);
    if (pending_words.size() != 0)
      $display("%0d expected words never arrived", pending_words.size());
    if (errors == 0 && pending_words.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> complex_fir_block_filter.f
src/cfbf_pkg.sv
src/cfbf_ctrl.sv
src/cfbf_datapath.sv
src/complex_fir_block_filter.sv
test/complex_fir_block_filter_tb.sv
